>>> design/scpd_pkg.sv
// Shared types and constants for the serial command pulse driver.
`timescale 1ns / 1ps
package scpd_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 12;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 16;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_CLAP_DEFAULT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOUTH_COOL    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLUID_PULSE   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLUID_COOL    = 8'd3;

    // Characters
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [9:0] MAX_UNITS = 10'd300;

    typedef enum logic [1:0] {
        CODE_NONE,
        CODE_CLAP,
        CODE_MOUTH,
        CODE_EYE
    } code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DECODE,
        S_CMD,
        S_FLUID,
        S_COOL,
        S_END,
        S_RETRY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic decode;
        logic run_cmd;
        logic end_pulses;
        logic retry;
        logic fluid;
        logic cool;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic out_free;
    } status_t;

endpackage

>>> design/scpd_ctrl.sv
// Sequencing state machine for the serial command pulse driver.
`timescale 1ns / 1ps
module scpd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  scpd_pkg::status_t status,
    output scpd_pkg::cmd_t    cmd
);
    import scpd_pkg::*;

    state_t state_reg, state_next;
    logic   retry_pass_reg, retry_pass_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            retry_pass_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            retry_pass_reg <= retry_pass_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        retry_pass_next = retry_pass_reg;
        unique case (state_reg)
            S_IDLE: begin
                retry_pass_next = 1'b0;
                if (s_tvalid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:   state_next = status.is_tick ? S_END : S_DECODE;
            S_DECODE: state_next = S_CMD;
            S_CMD:    state_next = S_FLUID;
            S_FLUID:  state_next = S_COOL;
            S_COOL:   state_next = retry_pass_reg ? S_DONE : S_END;
            S_END:    state_next = S_RETRY;
            S_RETRY: begin
                retry_pass_next = 1'b1;
                state_next      = S_FLUID;
            end
            S_DONE: begin
                if (status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd        = '0;
        s_tready   = (state_reg == S_IDLE);
        cmd.accept = (state_reg == S_IDLE) && s_tvalid;
        cmd.load       = (state_reg == S_LOAD);
        cmd.decode     = (state_reg == S_DECODE);
        cmd.run_cmd    = (state_reg == S_CMD);
        cmd.fluid      = (state_reg == S_FLUID);
        cmd.cool       = (state_reg == S_COOL);
        cmd.end_pulses = (state_reg == S_END);
        cmd.retry      = (state_reg == S_RETRY);
        cmd.emit       = (state_reg == S_DONE) && status.out_free;
    end

endmodule

>>> design/scpd_datapath.sv
// Receive store, timers, pulse state, jitter and duty arithmetic.
`timescale 1ns / 1ps
module scpd_datapath #(
    parameter int RX_DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scpd_pkg::cmd_t                   cmd,
    output scpd_pkg::status_t                status,
    input  logic                             in_func,
    input  logic [scpd_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                             cfg_we,
    input  logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scpd_pkg::CFG_DAT_W-1:0]   cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [scpd_pkg::OUT_DATA_W-1:0]  out_data
);
    import scpd_pkg::*;

    localparam int CW = $clog2(RX_DEPTH + 1);
    localparam int IW = $clog2(RX_DEPTH);
    localparam logic [CW-1:0] FRAME_LEN = CW'(4);
    localparam logic [CW-1:0] DEPTH_C   = CW'(RX_DEPTH);

    // configuration
    logic [11:0] clap_default_reg, mouth_cool_reg;
    logic [9:0]  fluid_pulse_reg, fluid_cool_reg;

    // captured item
    logic        func_reg;
    logic [7:0]  byte_reg;
    logic [15:0] rp_reg, rc_reg;

    // receive store
    logic [7:0]    store_reg [RX_DEPTH];
    logic [CW-1:0] count_reg;

    // decoded command
    code_t       code_reg;
    logic [11:0] value_reg;

    // timing state
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] clap_end_reg, mouth_end_reg, fluid_end_reg;
    logic [TIME_W-1:0] clap_ready_reg, mouth_ready_reg, fluid_ready_reg;
    logic              clap_wait_reg, mouth_wait_reg;
    logic [11:0]       clap_len_reg, mouth_len_reg;
    logic [11:0]       eye_level_reg;
    logic              fluid_go_reg, fluid_set_reg, mouth_set_reg;

    // jitter remainders
    logic [30:0] p_prod_reg;
    logic [32:0] c_prod_reg;
    logic [7:0]  r201_reg;
    logic [5:0]  r61_reg;

    // duty pipeline
    logic [17:0] duty_p_reg, duty_p2_reg;
    logic [7:0]  duty_q_reg, duty_reg;

    logic        out_valid_reg;
    logic        out_clap_reg, out_mouth_reg, out_fluid_reg;
    logic [7:0]  out_duty_reg;

    // ---------------- frame decode ----------------
    logic [7:0]  up;
    logic        dig1, dig2, dig3, letter_ok, frame_ok, whitespace;
    logic [9:0]  units;
    logic [11:0] value;
    code_t       code;

    always_comb begin
        up = (store_reg[0] >= CH_LOW_A && store_reg[0] <= CH_LOW_Z) ?
             store_reg[0] - 8'd32 : store_reg[0];
        dig1 = store_reg[1] >= CH_0 && store_reg[1] <= CH_9;
        dig2 = store_reg[2] >= CH_0 && store_reg[2] <= CH_9;
        dig3 = store_reg[3] >= CH_0 && store_reg[3] <= CH_9;
        letter_ok = (up == CH_C) || (up == CH_M) || (up == CH_E);
        frame_ok  = letter_ok && dig1 && dig2 && dig3;
        units = 10'(store_reg[1][3:0]) * 10'd100 + 10'(store_reg[2][3:0]) * 10'd10
              + 10'(store_reg[3][3:0]);
        value = 12'(units) * 12'd10;
        if (up == CH_C) begin
            code = CODE_CLAP;
        end else if (up == CH_M) begin
            code = CODE_MOUTH;
        end else begin
            code = CODE_EYE;
        end
        whitespace = (byte_reg == CH_CR) || (byte_reg == CH_LF) ||
                     (byte_reg == CH_SPACE) || (byte_reg == CH_TAB);
    end

    // ---------------- jitter and pulse lengths ----------------
    logic [8:0]  q201;
    logic [10:0] q61;
    logic [16:0] rem201, rem61;
    logic [9:0]  lo_p, lo_c;
    logic [10:0] fluid_len, fluid_cd;
    logic [11:0] clap_dur;

    always_comb begin
        q201   = p_prod_reg[30:22];
        q61    = c_prod_reg[32:22];
        rem201 = 17'(rp_reg) - 17'(q201) * 17'd201;
        rem61  = 17'(rc_reg) - 17'(q61) * 17'd61;
        lo_p = (fluid_pulse_reg > 10'd101) ? fluid_pulse_reg - 10'd100 : 10'd1;
        lo_c = (fluid_cool_reg > 10'd31) ? fluid_cool_reg - 10'd30 : 10'd1;
        fluid_len = 11'(lo_p) + 11'(r201_reg);
        fluid_cd  = 11'(lo_c) + 11'(r61_reg);
        clap_dur  = (value_reg != 12'd0) ? value_reg : clap_default_reg;
    end

    // ---------------- duty pipeline ----------------
    logic [9:0]  lvl;
    logic [31:0] duty_prod;
    logic [17:0] duty_rem;

    always_comb begin
        lvl       = (eye_level_reg > 12'd1000) ? 10'd1000 : eye_level_reg[9:0];
        duty_prod = 32'(duty_p_reg) * 32'd8388;
        duty_rem  = duty_p2_reg - 18'(duty_q_reg) * 18'd1000;
    end

    always_ff @(posedge aclk) begin
        duty_p_reg  <= 18'(lvl) * 18'd255;
        duty_p2_reg <= duty_p_reg;
        duty_q_reg  <= duty_prod[30:23];
        duty_reg    <= (duty_rem >= 18'd1000) ? duty_q_reg + 8'd1 : duty_q_reg;

        p_prod_reg <= 31'(rp_reg) * 31'd20867;
        c_prod_reg <= 33'(rc_reg) * 33'd68759;
        r201_reg   <= (rem201 >= 17'd201) ? 8'(rem201 - 17'd201) : rem201[7:0];
        r61_reg    <= (rem61 >= 17'd61) ? 6'(rem61 - 17'd61) : rem61[5:0];
    end

    // ---------------- item capture and receive store ----------------
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg <= in_func;
            byte_reg <= in_data[7:0];
            rp_reg   <= in_data[23:8];
            rc_reg   <= in_data[39:24];
        end
        if (cmd.load && !func_reg && !whitespace) begin
            if (count_reg < DEPTH_C) begin
                store_reg[count_reg[IW-1:0]] <= byte_reg;
            end else begin
                for (int i = 0; i < RX_DEPTH - 1; i++) begin
                    store_reg[i] <= store_reg[i+1];
                end
                store_reg[RX_DEPTH-1] <= byte_reg;
            end
        end
        if (cmd.decode && count_reg >= FRAME_LEN) begin
            if (frame_ok) begin
                for (int i = 0; i < RX_DEPTH - 4; i++) begin
                    store_reg[i] <= store_reg[i+4];
                end
            end else begin
                for (int i = 0; i < RX_DEPTH - 1; i++) begin
                    store_reg[i] <= store_reg[i+1];
                end
            end
        end
        if (cmd.decode) begin
            value_reg <= value;
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clap_default_reg <= 12'd40;
            mouth_cool_reg   <= 12'd50;
            fluid_pulse_reg  <= 10'd250;
            fluid_cool_reg   <= 10'd100;
            count_reg        <= '0;
            code_reg         <= CODE_NONE;
            now_reg          <= '0;
            clap_end_reg     <= '0;
            mouth_end_reg    <= '0;
            fluid_end_reg    <= '0;
            clap_ready_reg   <= '0;
            mouth_ready_reg  <= '0;
            fluid_ready_reg  <= '0;
            clap_wait_reg    <= 1'b0;
            mouth_wait_reg   <= 1'b0;
            clap_len_reg     <= 12'd40;
            mouth_len_reg    <= 12'd100;
            eye_level_reg    <= '0;
            fluid_go_reg     <= 1'b0;
            fluid_set_reg    <= 1'b0;
            mouth_set_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_CLAP_DEFAULT: clap_default_reg <= cfg_data;
                    REG_MOUTH_COOL:   mouth_cool_reg   <= cfg_data;
                    REG_FLUID_PULSE:  fluid_pulse_reg  <= cfg_data[9:0];
                    REG_FLUID_COOL:   fluid_cool_reg   <= cfg_data[9:0];
                    default: ;
                endcase
            end

            if (cmd.load) begin
                if (func_reg) begin
                    now_reg <= now_reg + 32'd1;
                end else if (!whitespace && count_reg < DEPTH_C) begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            if (cmd.decode) begin
                code_reg <= CODE_NONE;
                if (count_reg >= FRAME_LEN) begin
                    if (frame_ok) begin
                        count_reg <= count_reg - FRAME_LEN;
                        if (units <= MAX_UNITS) begin
                            code_reg <= code;
                        end
                    end else begin
                        count_reg <= count_reg - CW'(1);
                    end
                end
            end

            if (cmd.run_cmd) begin
                fluid_go_reg  <= 1'b0;
                mouth_set_reg <= 1'b0;
                unique case (code_reg)
                    CODE_CLAP: begin
                        if (now_reg >= clap_ready_reg) begin
                            clap_end_reg   <= now_reg + 32'(clap_dur);
                            clap_ready_reg <= now_reg + 32'(clap_dur);
                            fluid_go_reg   <= 1'b1;
                            clap_wait_reg  <= 1'b0;
                        end else begin
                            clap_wait_reg <= 1'b1;
                            clap_len_reg  <= clap_dur;
                        end
                    end
                    CODE_MOUTH: begin
                        if (value_reg != 12'd0) begin
                            if (now_reg >= mouth_ready_reg) begin
                                mouth_end_reg  <= now_reg + 32'(value_reg);
                                mouth_set_reg  <= 1'b1;
                                mouth_wait_reg <= 1'b0;
                            end else begin
                                mouth_wait_reg <= 1'b1;
                                mouth_len_reg  <= value_reg;
                            end
                        end
                    end
                    CODE_EYE:  eye_level_reg <= value_reg;
                    CODE_NONE: ;
                    default: ;
                endcase
            end

            if (cmd.retry) begin
                fluid_go_reg  <= 1'b0;
                mouth_set_reg <= 1'b0;
                if (clap_wait_reg && now_reg >= clap_ready_reg) begin
                    clap_end_reg   <= now_reg + 32'(clap_len_reg);
                    clap_ready_reg <= now_reg + 32'(clap_len_reg);
                    fluid_go_reg   <= 1'b1;
                    clap_wait_reg  <= 1'b0;
                end
                if (mouth_wait_reg && now_reg >= mouth_ready_reg) begin
                    mouth_end_reg  <= now_reg + 32'(mouth_len_reg);
                    mouth_set_reg  <= 1'b1;
                    mouth_wait_reg <= 1'b0;
                end
            end

            if (cmd.fluid) begin
                fluid_set_reg <= 1'b0;
                if (fluid_go_reg && now_reg >= fluid_ready_reg) begin
                    fluid_end_reg <= now_reg + 32'(fluid_len);
                    fluid_set_reg <= 1'b1;
                end
            end

            if (cmd.cool) begin
                if (fluid_set_reg) begin
                    fluid_ready_reg <= fluid_end_reg + 32'(fluid_cd);
                end
                if (mouth_set_reg) begin
                    mouth_ready_reg <= mouth_end_reg + 32'(mouth_cool_reg);
                end
            end

            if (cmd.end_pulses) begin
                if (clap_end_reg != '0 && now_reg >= clap_end_reg) begin
                    clap_end_reg <= '0;
                end
                if (mouth_end_reg != '0 && now_reg >= mouth_end_reg) begin
                    mouth_end_reg <= '0;
                end
                if (fluid_end_reg != '0 && now_reg >= fluid_end_reg) begin
                    fluid_end_reg <= '0;
                end
            end

            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_clap_reg  <= (clap_end_reg != '0);
            out_mouth_reg <= (mouth_end_reg != '0);
            out_fluid_reg <= (fluid_end_reg != '0);
            out_duty_reg  <= duty_reg;
        end
    end

    assign status.is_tick  = func_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0, out_duty_reg, out_fluid_reg, out_mouth_reg, out_clap_reg};

endmodule

>>> design/serial_command_pulse_driver.sv
// Top level of the serial command pulse driver: controller plus datapath.
`timescale 1ns / 1ps
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tuser: func; tdata: rx_byte, rand_pulse, rand_cooldown
// m_        out  m_tvalid/m_tready  tdata: clap, mouth, fluid drive, eye_duty
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// From transfer to result the sequencer walks the frame check, command, fluid
// start, cooldown, pulse end and retry steps one per cycle; a tick item skips
// the frame check and command. One item is in flight at a time.
// The result sits in an output register, so the next item is taken while it
// waits; a stalled result holds the sequencer only at its final step.
// aresetn is synchronous and active low; the receive store holds no reset.
module serial_command_pulse_driver #(
    parameter int RX_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [23:8] rand_pulse, [39:24] rand_cooldown
    input  logic        s_tuser,   // [0] func: 0 byte, 1 millisecond tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] clap, [1] mouth, [2] fluid, [10:3] eye_duty, rest 0
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    import scpd_pkg::*;

    cmd_t    cmd;
    status_t status;

    // configuration writes land in the cycle after they are offered
    assign cfg_ready = 1'b1;

    scpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    scpd_datapath #(
        .RX_DEPTH (RX_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_func   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> design/scpd_checker.sv
// Port-level checks for the serial command pulse driver, bound to the top.
`timescale 1ns / 1ps
module scpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time: after a transfer the input side closes
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // pad bits above the duty stay clear
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("result pad bits set");

    // reset drops the result channel
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind serial_command_pulse_driver scpd_checker u_scpd_checker (.*);

>>> tb/serial_command_pulse_driver_tb.sv
// Self-checking testbench for the serial command pulse driver.
`timescale 1ns / 1ps
module serial_command_pulse_driver_tb;
    import scpd_pkg::*;

    localparam int RX_SLOTS = 16;
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Fields of one result transfer
    typedef struct packed {
        logic       clap;
        logic       mouth;
        logic       fluid;
        logic [7:0] duty;
    } drive_t;

    // One row of the directed table; check_now marks rows whose result is typed in
    typedef struct {
        logic        func;
        logic [7:0]  ch;
        logic [15:0] rp;
        logic [15:0] rc;
        bit          check_now;
        drive_t      want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [11:0] cfg_data = '0;

    serial_command_pulse_driver dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Predictor copy of the block's registers and state
    logic [11:0] clap_dflt, mouth_cool;
    logic [9:0]  fl_pulse, fl_cool;
    logic [31:0] now_ms, clap_end, mouth_end, fluid_end;
    logic [31:0] clap_rdy, mouth_rdy, fluid_rdy;
    bit          clap_pend, mouth_pend;
    logic [11:0] clap_plen, mouth_plen, eye_lvl;
    logic [7:0]  rx_buf [RX_SLOTS];
    int          rx_n;

    drive_t      drive_q [$];
    int          errors = 0;

    function automatic logic [7:0] upper(logic [7:0] c);
        return (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - 8'd32 : c;
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void shift_out(int n);
        if (n >= rx_n) begin
            rx_n = 0;
        end else begin
            for (int i = 0; i < rx_n - n; i++) rx_buf[i] = rx_buf[i + n];
            rx_n -= n;
        end
    endfunction

    function automatic void fluid_start(logic [15:0] rp, logic [15:0] rc);
        logic [31:0] lo_p, lo_c;
        if (now_ms < fluid_rdy) return;
        lo_p = fl_pulse > 101 ? fl_pulse - 100 : 1;
        lo_c = fl_cool > 31 ? fl_cool - 30 : 1;
        fluid_end = now_ms + lo_p + (rp % 201);
        fluid_rdy = fluid_end + lo_c + (rc % 61);
    endfunction

    function automatic bit clap_fire(logic [31:0] dur);
        if (now_ms < clap_rdy) return 0;
        clap_end = now_ms + dur;
        clap_rdy = now_ms + dur;
        return 1;
    endfunction

    function automatic bit mouth_fire(logic [31:0] dur);
        if (now_ms < mouth_rdy) return 0;
        mouth_end = now_ms + dur;
        mouth_rdy = mouth_end + mouth_cool;
        return 1;
    endfunction

    function automatic void run_frame(logic [7:0] code, logic [31:0] ms, logic [15:0] rp,
                                      logic [15:0] rc);
        logic [31:0] dur;
        if (code == CH_C) begin
            dur = ms > 0 ? ms : 32'(clap_dflt);
            if (clap_fire(dur)) begin
                fluid_start(rp, rc);
                clap_pend = 0;
            end else begin
                clap_pend = 1;
                clap_plen = dur[11:0];
            end
        end else if (code == CH_M && ms != 0) begin
            if (mouth_fire(ms)) begin
                mouth_pend = 0;
            end else begin
                mouth_pend = 1;
                mouth_plen = ms[11:0];
            end
        end else if (code == CH_E) begin
            eye_lvl = ms[11:0];
        end
    endfunction

    // Advance the predictor by one item and return the drive levels it implies
    function automatic drive_t predict_drive(logic func, logic [7:0] ch, logic [15:0] rp,
                                             logic [15:0] rc);
        drive_t d;
        logic [7:0] code;
        int units, lvl;
        if (func == FUNC_TICK) begin
            now_ms++;
        end else if (!(ch == CH_CR || ch == CH_LF || ch == CH_SPACE || ch == CH_TAB)) begin
            if (rx_n < RX_SLOTS) begin
                rx_buf[rx_n++] = ch;
            end else begin
                for (int i = 0; i < RX_SLOTS - 1; i++) rx_buf[i] = rx_buf[i + 1];
                rx_buf[RX_SLOTS - 1] = ch;
            end
            while (rx_n >= 4) begin
                code = upper(rx_buf[0]);
                if (!(code == CH_C || code == CH_M || code == CH_E) || !digit(rx_buf[1])
                    || !digit(rx_buf[2]) || !digit(rx_buf[3])) begin
                    shift_out(1);
                    continue;
                end
                units = (rx_buf[1] - CH_0) * 100 + (rx_buf[2] - CH_0) * 10
                        + (rx_buf[3] - CH_0);
                if (units <= MAX_UNITS) run_frame(code, units * 10, rp, rc);
                shift_out(4);
            end
        end
        if (clap_end != 0 && now_ms >= clap_end) clap_end = 0;
        if (mouth_end != 0 && now_ms >= mouth_end) mouth_end = 0;
        if (fluid_end != 0 && now_ms >= fluid_end) fluid_end = 0;
        if (clap_pend && now_ms >= clap_rdy) begin
            if (clap_fire(32'(clap_plen))) begin
                fluid_start(rp, rc);
                clap_pend = 0;
            end
        end
        if (mouth_pend && now_ms >= mouth_rdy) begin
            if (mouth_fire(32'(mouth_plen))) mouth_pend = 0;
        end
        lvl = eye_lvl > 1000 ? 1000 : eye_lvl;
        d.clap = clap_end != 0;
        d.mouth = mouth_end != 0;
        d.fluid = fluid_end != 0;
        d.duty = 8'((lvl * 255) / 1000);
        return d;
    endfunction

    task automatic predictor_reset();
        clap_dflt = 40; mouth_cool = 50; fl_pulse = 250; fl_cool = 100;
        now_ms = 0; clap_end = 0; mouth_end = 0; fluid_end = 0;
        clap_rdy = 0; mouth_rdy = 0; fluid_rdy = 0;
        clap_pend = 0; mouth_pend = 0; clap_plen = 40; mouth_plen = 100;
        eye_lvl = 0; rx_n = 0;
    endtask

    // Write one register over the configuration channel while the block is idle
    task automatic write_reg(logic [7:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_CLAP_DEFAULT) clap_dflt = val;
        else if (idx == REG_MOUTH_COOL) mouth_cool = val;
        else if (idx == REG_FLUID_PULSE) fl_pulse = val[9:0];
        else if (idx == REG_FLUID_COOL) fl_cool = val[9:0];
    endtask

    // Send one item; burst gaps come from the caller
    task automatic send_item(logic func, logic [7:0] ch, logic [15:0] rp, logic [15:0] rc);
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {rc, rp, ch};
        do @(posedge aclk); while (!s_tready);
        drive_q.push_back(predict_drive(func, ch, rp, rc));
    endtask

    int burst_left = 0;

    task automatic paced_send(logic func, logic [7:0] ch, logic [15:0] rp, logic [15:0] rc);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_item(func, ch, rp, rc);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // Receiver stalls on a slowly varying duty pattern, with stall-free stretches
    int stall_mode = 0;
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        drive_t got, exp_d;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[10:3]};
            if (drive_q.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                errors++;
            end else begin
                exp_d = drive_q.pop_front();
                if (got.clap !== exp_d.clap) begin
                    $error("clap_drive: expected %0d actual %0d", exp_d.clap, got.clap);
                    errors++;
                end
                if (got.mouth !== exp_d.mouth) begin
                    $error("mouth_drive: expected %0d actual %0d", exp_d.mouth, got.mouth);
                    errors++;
                end
                if (got.fluid !== exp_d.fluid) begin
                    $error("fluid_drive: expected %0d actual %0d", exp_d.fluid, got.fluid);
                    errors++;
                end
                if (got.duty !== exp_d.duty) begin
                    $error("eye_duty: expected %0d actual %0d", exp_d.duty, got.duty);
                    errors++;
                end
                if (m_tdata[15:11] !== '0) begin
                    $error("pad bits: expected 0 actual %h", m_tdata[15:11]);
                    errors++;
                end
            end
        end
    end

    // Pick a random byte, biased toward frame characters
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(0, 255));
            1: return CH_0 + 8'($urandom_range(0, 9));
            2: return 8'h53;
            3: return CH_SPACE;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic logic [7:0] frame_letter();
        logic [7:0] l;
        case ($urandom_range(0, 2))
            0: l = CH_C;
            1: l = CH_M;
            default: l = CH_E;
        endcase
        return $urandom_range(0, 1) ? l : l + 8'd32;
    endfunction

    // Directed rows: extremes, each command, each special case
    row_t plan [$];

    task automatic add_row(logic func, logic [7:0] ch, bit chk = 0, drive_t w = '0);
        row_t r;
        r.func = func; r.ch = ch; r.rp = 16'hFFFF; r.rc = 16'h0000;
        r.check_now = chk; r.want = w;
        plan.push_back(r);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_row(FUNC_BYTE, s[i]);
    endtask

    task automatic send_frame(logic [7:0] l, int units);
        logic [15:0] rp, rc;
        int v;
        v = units;
        rp = 16'($urandom_range(0, 65535));
        rc = 16'($urandom_range(0, 65535));
        paced_send(FUNC_BYTE, l, rp, rc);
        paced_send(FUNC_BYTE, CH_0 + 8'(v / 100), rp, rc);
        paced_send(FUNC_BYTE, CH_0 + 8'((v / 10) % 10), rp, rc);
        paced_send(FUNC_BYTE, CH_0 + 8'(v % 10), rp, rc);
    endtask

    initial begin : stimulus
        drive_t w;
        int sent, nticks;
        row_t r;
        predictor_reset();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Typed-in rows: idle after reset, eye full scale and over-range
        add_row(FUNC_TICK, 8'h00, 1, '0);
        add_text("E100");
        w = '0; w.duty = 8'd255;
        add_row(FUNC_BYTE, CH_SPACE, 1, w);
        add_text("E999");
        add_row(FUNC_BYTE, CH_TAB, 1, w);
        add_text("m000 c000S1234 \r\nx");
        add_row(FUNC_TICK, 8'hFF);
        add_text("M300");
        add_text("e000");
        foreach (plan[i]) begin
            r = plan[i];
            send_item(r.func, r.ch, r.rp, r.rc);
            if (r.check_now && drive_q[$] != r.want) begin
                $error("directed row %0d: expected %h actual %h", i, r.want, drive_q[$]);
                errors++;
            end
        end
        drain();

        // Register extremes, then a blocked clap that fires once ready and a blocked mouth that stays pending
        write_reg(REG_CLAP_DEFAULT, 12'd0);
        write_reg(REG_MOUTH_COOL, 12'd3000);
        write_reg(REG_FLUID_PULSE, 12'd101);
        write_reg(REG_FLUID_COOL, 12'd31);
        write_reg(8'hFF, 12'hFFF);
        send_frame(CH_C, 0);
        send_frame(CH_C, 5);
        send_frame(CH_C, 3);
        send_frame(CH_M, 1);
        send_frame(CH_M, 2);
        for (int i = 0; i < 80; i++) paced_send(FUNC_TICK, 8'h00, 16'h0000, 16'hFFFF);
        drain();

        // Random phases under several register settings
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_CLAP_DEFAULT, 12'd3000);
                    write_reg(REG_MOUTH_COOL, 12'd0);
                    write_reg(REG_FLUID_PULSE, 12'd1000);
                    write_reg(REG_FLUID_COOL, 12'd1000);
                end
                1: begin
                    write_reg(REG_CLAP_DEFAULT, 12'd1);
                    write_reg(REG_MOUTH_COOL, 12'd7);
                    write_reg(REG_FLUID_PULSE, 12'd101);
                    write_reg(REG_FLUID_COOL, 12'd31);
                end
                2: begin
                    write_reg(REG_CLAP_DEFAULT, 12'($urandom_range(1, 60)));
                    write_reg(REG_MOUTH_COOL, 12'($urandom_range(0, 40)));
                    write_reg(REG_FLUID_PULSE, 12'($urandom_range(101, 1000)));
                    write_reg(REG_FLUID_COOL, 12'($urandom_range(31, 1000)));
                end
                default: begin
                    write_reg(REG_CLAP_DEFAULT, 12'd40);
                    write_reg(REG_MOUTH_COOL, 12'd50);
                    write_reg(REG_FLUID_PULSE, 12'd250);
                    write_reg(REG_FLUID_COOL, 12'd100);
                end
            endcase
            while (sent < 400 * (ph + 1)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        // Small values mostly, so pulses end within the ticks sent
                        send_frame(frame_letter(), $urandom_range(0, 3) == 0 ?
                                   $urandom_range(0, 999) : $urandom_range(0, 4));
                        sent += 4;
                    end
                    4, 5, 6, 7: begin
                        nticks = $urandom_range(1, 30);
                        for (int k = 0; k < nticks; k++)
                            paced_send(FUNC_TICK, 8'($urandom_range(0, 255)),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)));
                        sent += nticks;
                    end
                    default: begin
                        paced_send(FUNC_BYTE, noise_byte(), 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)));
                        sent++;
                    end
                endcase
            end
            drain();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Generous ceiling on the whole run
    initial begin : watchdog
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule
